FILE: rtl/core/bld_pkg.sv
// ============================================================================
// bld_pkg
// Shared types and constants of the breakpoint linearizer with deadband.
// ============================================================================
package bld_pkg;

   // Curve geometry and data widths.
   localparam int PTS    = 6;
   localparam int DATA_W = 16;

   // Valid channel range.
   localparam logic [3:0] CH_MIN = 4'd1;
   localparam logic [3:0] CH_MAX = 4'd8;

   // Configuration register indexes.
   localparam logic [2:0] CSR_X_LOW    = 3'd0;
   localparam logic [2:0] CSR_X_HIGH   = 3'd1;
   localparam logic [2:0] CSR_Y_LOW    = 3'd2;
   localparam logic [2:0] CSR_Y_HIGH   = 3'd3;
   localparam logic [2:0] CSR_DEADBAND = 3'd4;

   // Register values after reset: x = 0,10,20,30,40,50 and y = 0,200,...,1000.
   localparam logic [63:0] X_LOW_RST    = 64'h001E_0014_000A_0000;
   localparam logic [31:0] X_HIGH_RST   = 32'h0032_0028;
   localparam logic [63:0] Y_LOW_RST    = 64'h0258_0190_00C8_0000;
   localparam logic [31:0] Y_HIGH_RST   = 32'h03E8_0320;
   localparam logic [15:0] DEADBAND_RST = 16'd20;

   // All breakpoints of one axis, point 0 in the lowest bits.
   typedef logic [PTS-1:0][DATA_W-1:0] bld_pts_type;

   // Control word that rides along with every item.
   typedef struct packed {
      logic              ch_ok;      // channel in the valid range
      logic              direct;     // result taken straight from a breakpoint
      logic [DATA_W-1:0] direct_val; // that breakpoint value
      logic              neg;        // segment slope is negative
      logic [DATA_W-1:0] yb;         // value at the upper breakpoint
      logic [DATA_W-1:0] prev;       // previously reported value
   } bld_ctl_type;

   // Output of the segment select stage.
   typedef struct packed {
      bld_ctl_type       ctl;
      logic [DATA_W-1:0] den;  // x[i] - x[i-1]
      logic [DATA_W-1:0] mag;  // |y[i] - y[i-1]|
      logic [DATA_W-1:0] t;    // x[i] - sample
   } bld_seg_type;

   // Output of the multiplier stage.
   typedef struct packed {
      bld_ctl_type         ctl;
      logic [DATA_W-1:0]   den;
      logic [2*DATA_W-1:0] prod;
   } bld_prod_type;

   // Partial division state between divider stages.
   typedef struct packed {
      bld_ctl_type       ctl;
      logic [DATA_W-1:0] den;
      logic [DATA_W-1:0] rem;   // running remainder, always below den
      logic [DATA_W-1:0] rest;  // dividend bits not yet shifted in
      logic [DATA_W-1:0] quo;   // quotient bits so far
   } bld_div_type;

endpackage

FILE: rtl/core/bld_seg.sv
// ============================================================================
// bld_seg
// Segment select stage: finds the breakpoint interval of the sample and
// registers the operands of the interpolation.
// ============================================================================
module bld_seg (
   input  logic                 clock,
   input  logic                 en,
   input  bld_pkg::bld_pts_type x_pts,
   input  bld_pkg::bld_pts_type y_pts,
   input  logic [3:0]           channel,
   input  logic [15:0]          sample,
   input  logic [15:0]          prev,
   output bld_pkg::bld_seg_type seg_ff
);
   import bld_pkg::*;

   logic              found;
   logic [2:0]        idx;
   logic [2:0]        idx_lo;
   logic [DATA_W-1:0] xa;
   logic [DATA_W-1:0] xb;
   logic [DATA_W-1:0] ya;
   logic [DATA_W-1:0] yb;
   bld_seg_type       seg_in;

   // First breakpoint at or above the sample; the lowest match wins.
   always_comb begin
      found = 1'b0;
      idx   = 3'd0;
      for (int k = PTS - 1; k >= 0; k--) begin
         if (sample <= x_pts[k]) begin
            found = 1'b1;
            idx   = 3'(k);
         end
      end
   end

   // Operands of the chosen segment.
   always_comb begin
      idx_lo = (idx == 3'd0) ? 3'd0 : idx - 3'd1;
      xa     = x_pts[idx_lo];
      xb     = x_pts[idx];
      ya     = y_pts[idx_lo];
      yb     = y_pts[idx];

      seg_in.ctl.ch_ok      = (channel >= CH_MIN) && (channel <= CH_MAX);
      seg_in.ctl.direct     = !found || (idx == 3'd0);
      seg_in.ctl.direct_val = found ? y_pts[0] : y_pts[PTS-1];
      seg_in.ctl.neg        = (yb < ya);
      seg_in.ctl.yb         = yb;
      seg_in.ctl.prev       = prev;
      seg_in.den            = xb - xa;
      seg_in.mag            = (yb < ya) ? (ya - yb) : (yb - ya);
      seg_in.t              = xb - sample;
   end

   // Stage register.
   always_ff @(posedge clock) begin
      if (en) begin
         seg_ff <= seg_in;
      end
   end

endmodule

FILE: rtl/core/bld_div.sv
// ============================================================================
// bld_div
// One stage of the pipelined restoring divider: resolves STEPS quotient bits
// of the product divided by the segment width.
// ============================================================================
module bld_div #(
   parameter int STEPS = 4
) (
   input  logic                 clock,
   input  logic                 en,
   input  bld_pkg::bld_div_type d_in,
   output bld_pkg::bld_div_type d_ff
);
   import bld_pkg::*;

   bld_div_type d_in_next;

   // Shift in one dividend bit per step and subtract where it fits.
   always_comb begin
      logic [DATA_W:0] rem_wide;
      bld_div_type     cur;
      cur = d_in;
      for (int s = 0; s < STEPS; s++) begin
         rem_wide = {cur.rem, cur.rest[DATA_W-1]};
         cur.rest = {cur.rest[DATA_W-2:0], 1'b0};
         if (rem_wide >= {1'b0, cur.den}) begin
            cur.rem = DATA_W'(rem_wide - {1'b0, cur.den});
            cur.quo = {cur.quo[DATA_W-2:0], 1'b1};
         end else begin
            cur.rem = rem_wide[DATA_W-1:0];
            cur.quo = {cur.quo[DATA_W-2:0], 1'b0};
         end
      end
      d_in_next = cur;
   end

   // Stage register.
   always_ff @(posedge clock) begin
      if (en) begin
         d_ff <= d_in_next;
      end
   end

endmodule

FILE: rtl/core/bld_out.sv
// ============================================================================
// bld_out
// Result stages: applies the floored quotient to the upper breakpoint value,
// then compares against the previous value for the deadband.
// ============================================================================
module bld_out (
   input  logic                 clock,
   input  logic [1:0]           en,
   input  bld_pkg::bld_div_type d_in,
   input  logic [15:0]          deadband,
   output logic [15:0]          value_ff,
   output logic                 held_ff
);
   import bld_pkg::*;

   logic signed [DATA_W+1:0] sum;
   logic [DATA_W-1:0]        nv_in;
   logic [DATA_W-1:0]        nv_ff;
   bld_ctl_type              ctl_ff;
   logic [DATA_W-1:0]        diff;
   logic                     held_in;
   logic [DATA_W-1:0]        value_in;

   // A rising segment rounds the subtracted part up, a falling one adds the
   // floored quotient.
   always_comb begin
      if (d_in.ctl.neg) begin
         sum = $signed({2'b00, d_in.ctl.yb}) + $signed({2'b00, d_in.quo});
      end else begin
         sum = $signed({2'b00, d_in.ctl.yb}) - $signed({2'b00, d_in.quo})
               - $signed({17'd0, (d_in.rem != '0)});
      end
      if (d_in.ctl.direct) begin
         nv_in = d_in.ctl.direct_val;
      end else if (sum < 0) begin
         nv_in = '0;
      end else if (sum > $signed(18'd65535)) begin
         nv_in = '1;
      end else begin
         nv_in = sum[DATA_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         nv_ff  <= nv_in;
         ctl_ff <= d_in.ctl;
      end
   end

   // Deadband against the previously reported value.
   always_comb begin
      diff     = (ctl_ff.prev > nv_ff) ? (ctl_ff.prev - nv_ff) : (nv_ff - ctl_ff.prev);
      held_in  = ctl_ff.ch_ok && (diff <= deadband);
      if (!ctl_ff.ch_ok) begin
         value_in = '0;
      end else if (held_in) begin
         value_in = ctl_ff.prev;
      end else begin
         value_in = nv_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en[1]) begin
         value_ff <= value_in;
         held_ff  <= held_in;
      end
   end

endmodule

FILE: rtl/core/breakpoint_linearizer_deadband.sv
// ============================================================================
// breakpoint_linearizer_deadband
// Six-point piecewise linear calibration of raw samples with a deadband.
// ============================================================================
// Usage:
// Items enter on the req_ stream: channel in req_tuser, sample and previous
// value in req_tdata. Each item yields exactly one result on the rsp_ stream:
// the linearized value in rsp_tdata and the held flag in rsp_tuser.
// Channels outside 1..8 give value 0 with held clear.
// The curve and the deadband are written through the csr_ channel, which is
// always ready; write it only while no transaction is in flight.
// From input transaction to rsp_tvalid an item passes through segment
// select, a 16x16 multiplier, the divider stages at DIV_BITS quotient bits
// each, the result stage and the deadband output register. One item is
// accepted every cycle as long as the receiver keeps up with the results.
// When the receiver stalls, valid items pile up toward the output and empty
// stages keep taking new items; req_tready drops only once every stage is
// full. Reset clears all stage valid bits and restores the default curve
// (x = 0..50 in steps of 10, y = 0..1000 in steps of 200, deadband 20).
// ============================================================================
module breakpoint_linearizer_deadband #(
   parameter int DIV_BITS = 4
) (
   input  logic        clock,
   input  logic        reset,
   // Input stream.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [15:0] sample, [31:16] previous_value
   input  logic [3:0]  req_tuser,   // [3:0] channel
   // Result stream.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [15:0] value
   output logic        rsp_tuser,   // [0] held
   // Configuration writes.
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [63:0] csr_data
);
   import bld_pkg::*;

   localparam int DIV_STAGES = DATA_W / DIV_BITS;
   localparam int NS         = DIV_STAGES + 4;

   logic [63:0]  x_low_ff;
   logic [31:0]  x_high_ff;
   logic [63:0]  y_low_ff;
   logic [31:0]  y_high_ff;
   logic [15:0]  deadband_ff;
   bld_pts_type  x_pts;
   bld_pts_type  y_pts;

   logic [NS-1:0] en;
   logic [NS-1:0] vld_in;
   logic [NS-1:0] vld_ff;

   bld_seg_type  seg_ff;
   bld_prod_type prod_in;
   bld_prod_type prod_ff;
   bld_div_type  div_d [DIV_STAGES+1];

   // Configuration registers.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         x_low_ff    <= X_LOW_RST;
         x_high_ff   <= X_HIGH_RST;
         y_low_ff    <= Y_LOW_RST;
         y_high_ff   <= Y_HIGH_RST;
         deadband_ff <= DEADBAND_RST;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_X_LOW:    x_low_ff    <= csr_data;
            CSR_X_HIGH:   x_high_ff   <= csr_data[31:0];
            CSR_Y_LOW:    y_low_ff    <= csr_data;
            CSR_Y_HIGH:   y_high_ff   <= csr_data[31:0];
            CSR_DEADBAND: deadband_ff <= csr_data[15:0];
            default: ;
         endcase
      end
   end

   assign x_pts = {x_high_ff, x_low_ff};
   assign y_pts = {y_high_ff, y_low_ff};

   // Stage enables: a stage moves when it is empty or the next one moves.
   always_comb begin
      en[NS-1] = !vld_ff[NS-1] || rsp_tready;
      for (int k = NS - 2; k >= 0; k--) begin
         en[k] = !vld_ff[k] || en[k+1];
      end
   end

   assign req_tready = en[0];

   // Valid bits travel with the data.
   always_comb begin
      vld_in[0] = en[0] ? req_tvalid : vld_ff[0];
      for (int k = 1; k < NS; k++) begin
         vld_in[k] = en[k] ? vld_ff[k-1] : vld_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   // Segment select.
   bld_seg u_seg (
      .clock   (clock),
      .en      (en[0]),
      .x_pts   (x_pts),
      .y_pts   (y_pts),
      .channel (req_tuser),
      .sample  (req_tdata[15:0]),
      .prev    (req_tdata[31:16]),
      .seg_ff  (seg_ff)
   );

   // Product of slope magnitude and distance to the upper breakpoint.
   always_comb begin
      prod_in.ctl  = seg_ff.ctl;
      prod_in.den  = seg_ff.den;
      prod_in.prod = (2*DATA_W)'(seg_ff.mag) * (2*DATA_W)'(seg_ff.t);
   end

   always_ff @(posedge clock) begin
      if (en[1]) begin
         prod_ff <= prod_in;
      end
   end

   // The product stays below den * 2^16, so its upper half seeds the remainder.
   always_comb begin
      div_d[0].ctl  = prod_ff.ctl;
      div_d[0].den  = prod_ff.den;
      div_d[0].rem  = prod_ff.prod[2*DATA_W-1:DATA_W];
      div_d[0].rest = prod_ff.prod[DATA_W-1:0];
      div_d[0].quo  = '0;
   end

   // Divider pipeline.
   for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
      bld_div #(
         .STEPS (DIV_BITS)
      ) u_div (
         .clock (clock),
         .en    (en[2+g]),
         .d_in  (div_d[g]),
         .d_ff  (div_d[g+1])
      );
   end

   // Result and deadband stages.
   bld_out u_out (
      .clock    (clock),
      .en       (en[NS-1:NS-2]),
      .d_in     (div_d[DIV_STAGES]),
      .deadband (deadband_ff),
      .value_ff (rsp_tdata),
      .held_ff  (rsp_tuser)
   );

   assign rsp_tvalid = vld_ff[NS-1];

   // A full pipeline facing a stalled receiver takes no new transaction.
   a_full_stall: assert property (@(posedge clock) disable iff (reset)
      ((&vld_ff) && !rsp_tready) |-> !req_tready)
      else $error("input accepted while every stage is full and stalled");

   // An accepted transaction occupies the first stage on the next cycle.
   a_accept_lands: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> vld_ff[0])
      else $error("accepted transaction did not reach the first stage");

   // The divider remainder stays below the segment width for interpolated items.
   a_div_rem: assert property (@(posedge clock) disable iff (reset)
      (vld_ff[NS-3] && !div_d[DIV_STAGES].ctl.direct)
         |-> (div_d[DIV_STAGES].rem < div_d[DIV_STAGES].den))
      else $error("divider remainder not below divisor");

endmodule

FILE: sim/breakpoint_linearizer_deadband_test.sv
`timescale 1ns / 1ps
// ============================================================================
// breakpoint_linearizer_deadband_test
// Self-checking testbench of the six-point calibration block with deadband.
// It streams samples through the block under several curves and deadbands,
// predicts each linearized reading locally and checks every result in order.
// ============================================================================
module breakpoint_linearizer_deadband_test;
   import bld_pkg::*;

   // Cycles without any transaction before the run is declared hung.
   localparam int HANG_LIMIT = 5000;
   // Cycles to let pass once the last reading has come back.
   localparam int DRAIN_CYCLES = 16;
   // Highest index the register port can address.
   localparam logic [2:0] CSR_INDEX_LAST = 3'd7;
   // Random items per curve and idling mode.
   localparam int ITEMS_PER_CURVE = 105;

   // Expected reading for one sample.
   typedef struct packed {
      logic [DATA_W-1:0] value;
      logic              held;
   } reading_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;   // [15:0] sample, [31:16] previous_value
   logic [3:0]  req_tuser = '0;   // [3:0] channel
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;        // [15:0] value
   logic        rsp_tuser;        // [0] held
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [2:0]  csr_index = '0;
   logic [63:0] csr_data = '0;

   // Local copy of the curve registers.
   logic [63:0]       cal_x_low = X_LOW_RST;
   logic [31:0]       cal_x_high = X_HIGH_RST;
   logic [63:0]       cal_y_low = Y_LOW_RST;
   logic [31:0]       cal_y_high = Y_HIGH_RST;
   logic [DATA_W-1:0] cal_deadband = DEADBAND_RST;

   reading_type pending_readings[$];
   int          mismatch_count = 0;
   int          hang_cycles = 0;
   int          req_idle_pct = 0;
   int          rsp_stall_pct = 0;

   breakpoint_linearizer_deadband i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   // Free-running clock, 20 ns period.
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Receiver back-pressure at the configured stall rate.
   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(0, 99) >= rsp_stall_pct);
   end

   // Breakpoint k of one axis, point 0 in the lowest bits of the low register.
   function automatic logic [DATA_W-1:0] curve_point(input logic [63:0] lo,
                                                     input logic [31:0] hi,
                                                     input int k);
      if (k < 4) return lo[16*k +: 16];
      return hi[16*(k-4) +: 16];
   endfunction

   // Piecewise linear mapping of a raw sample, floor of the exact quotient.
   function automatic int curve_value(input logic [DATA_W-1:0] smp);
      int     seg;
      longint xa, xb, ya, yb, num, den, quo, lin;
      seg = 0;
      while (seg < PTS && smp > curve_point(cal_x_low, cal_x_high, seg)) seg++;
      if (seg == 0) return int'(curve_point(cal_y_low, cal_y_high, 0));
      if (seg == PTS) return int'(curve_point(cal_y_low, cal_y_high, PTS - 1));
      xa = longint'(curve_point(cal_x_low, cal_x_high, seg - 1));
      xb = longint'(curve_point(cal_x_low, cal_x_high, seg));
      ya = longint'(curve_point(cal_y_low, cal_y_high, seg - 1));
      yb = longint'(curve_point(cal_y_low, cal_y_high, seg));
      den = xb - xa;
      num = (yb - ya) * (longint'(smp) - xb);
      quo = num / den;
      // Division truncates toward zero; step down for negative remainders.
      if ((num % den) != 0 && num < 0) quo = quo - 1;
      lin = yb + quo;
      if (lin < 0) lin = 0;
      if (lin > 65535) lin = 65535;
      return int'(lin);
   endfunction

   // Full reading: channel check, linearization and deadband hold.
   function automatic reading_type predict_reading(input logic [3:0] ch,
                                                   input logic [DATA_W-1:0] smp,
                                                   input logic [DATA_W-1:0] prev);
      reading_type rd;
      int          lin, diff;
      rd = '0;
      if (ch < CH_MIN || ch > CH_MAX) return rd;
      lin = curve_value(smp);
      diff = (int'(prev) > lin) ? int'(prev) - lin : lin - int'(prev);
      if (diff <= int'(cal_deadband)) begin
         rd.value = prev;
         rd.held = 1'b1;
      end else begin
         rd.value = lin[DATA_W-1:0];
      end
      return rd;
   endfunction

   // Send one sample; valid stays high after the transaction so that the
   // next call can either present new data or open a gap. Each cycle before
   // the sample idles with the configured probability.
   task automatic send_sample(input logic [3:0] ch, input logic [DATA_W-1:0] smp,
                              input logic [DATA_W-1:0] prev);
      int gap;
      gap = 0;
      while ($urandom_range(0, 99) < req_idle_pct) gap++;
      @(negedge clock);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= ch;
      req_tdata <= {prev, smp};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      pending_readings.push_back(predict_reading(ch, smp, prev));
   endtask

   // Stop sending and wait until every reading has come back.
   task automatic drain_pipeline();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending_readings.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // One register write transaction; the local copy follows the block.
   task automatic write_register(input logic [2:0] idx, input logic [63:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         CSR_X_LOW:    cal_x_low = data;
         CSR_X_HIGH:   cal_x_high = data[31:0];
         CSR_Y_LOW:    cal_y_low = data;
         CSR_Y_HIGH:   cal_y_high = data[31:0];
         CSR_DEADBAND: cal_deadband = data[DATA_W-1:0];
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Write a whole curve; narrow registers get junk in their unused upper bits.
   task automatic load_curve(input bld_pts_type xs, input bld_pts_type ys,
                             input logic [DATA_W-1:0] dband);
      write_register(CSR_X_LOW, {xs[3], xs[2], xs[1], xs[0]});
      write_register(CSR_X_HIGH, {$urandom(), xs[5], xs[4]});
      write_register(CSR_Y_LOW, {ys[3], ys[2], ys[1], ys[0]});
      write_register(CSR_Y_HIGH, {$urandom(), ys[5], ys[4]});
      write_register(CSR_DEADBAND, {$urandom(), 16'($urandom()), dband});
   endtask

   // Random samples, biased toward breakpoints and toward the deadband edge.
   task automatic stream_random_samples(input int count);
      logic [3:0]        ch;
      logic [DATA_W-1:0] smp, prev;
      int                pick, near, band, lin;
      for (int n = 0; n < count; n++) begin
         if ($urandom_range(0, 99) < 85) begin
            ch = 4'($urandom_range(CH_MIN, CH_MAX));
         end else begin
            pick = $urandom_range(0, 7);
            ch = (pick == 0) ? 4'd0 : CH_MAX + pick[3:0];
         end
         if ($urandom_range(0, 1) == 1) begin
            near = curve_point(cal_x_low, cal_x_high, $urandom_range(0, PTS - 1))
                   + $urandom_range(0, 6) - 3;
            if (near < 0) near = 0;
            if (near > 65535) near = 65535;
            smp = near[DATA_W-1:0];
         end else begin
            smp = 16'($urandom());
         end
         if ($urandom_range(0, 99) < 40) begin
            band = (int'(cal_deadband) > 1000) ? 1000 : int'(cal_deadband);
            lin = curve_value(smp);
            near = lin + $urandom_range(0, 2 * band + 4) - (band + 2);
            if (near < 0) near = 0;
            if (near > 65535) near = 65535;
            prev = near[DATA_W-1:0];
         end else begin
            prev = 16'($urandom());
         end
         send_sample(ch, smp, prev);
      end
   endtask

   // Default curve after reset: channel limits, ends of the curve, exact
   // breakpoints, interpolation and both sides of the deadband edge.
   task automatic test_reset_curve();
      req_idle_pct = 0;
      rsp_stall_pct = 0;
      send_sample(4'd0, 16'd25, 16'd500);
      send_sample(4'd9, 16'd25, 16'd500);
      send_sample(4'd15, 16'hFFFF, 16'hFFFF);
      send_sample(CH_MIN, 16'd0, 16'hFFFF);
      send_sample(CH_MAX, 16'hFFFF, 16'd0);
      send_sample(4'd2, 16'd10, 16'd0);
      send_sample(4'd3, 16'd15, 16'd0);
      send_sample(4'd4, 16'd13, 16'd280);
      send_sample(4'd5, 16'd13, 16'd281);
      send_sample(4'd6, 16'd13, 16'd240);
      send_sample(4'd7, 16'd50, 16'd1000);
      send_sample(CH_MIN, 16'd51, 16'hFFFF);
      send_sample(4'd0, 16'hFFFF, 16'hFFFF);
      drain_pipeline();
   endtask

   // Falling segments, unordered breakpoints, unused register indexes and
   // the deadband at both extremes.
   task automatic test_register_writes();
      bld_pts_type xs, ys;
      // Writes to indexes with no register behind them change nothing.
      for (int idx = CSR_DEADBAND + 1; idx <= CSR_INDEX_LAST; idx++) begin
         write_register(idx[2:0], {$urandom(), $urandom()});
      end
      send_sample(CH_MIN, 16'd33, 16'd0);
      xs = {16'd600, 16'd500, 16'd400, 16'd300, 16'd200, 16'd100};
      ys = {16'hFFFF, 16'd1, 16'd0, 16'd30000, 16'd50000, 16'hFFFF};
      drain_pipeline();
      load_curve(xs, ys, 16'd0);
      send_sample(CH_MIN, 16'd150, 16'd0);
      send_sample(4'd2, 16'd333, 16'd0);
      send_sample(4'd3, 16'd450, 16'd0);
      send_sample(4'd4, 16'd599, 16'd1);
      send_sample(4'd5, 16'd600, 16'hFFFF);
      send_sample(CH_MAX, 16'd99, 16'd0);
      drain_pipeline();
      write_register(CSR_DEADBAND, 64'hFFFF);
      send_sample(CH_MIN, 16'd250, 16'd0);
      send_sample(CH_MAX, 16'hFFFF, 16'hFFFF);
      send_sample(4'd12, 16'd250, 16'd0);
      drain_pipeline();
      // Breakpoints out of order: the search still takes the first fit.
      xs = {16'd300, 16'd600, 16'd200, 16'd400, 16'd100, 16'd500};
      ys = {16'd10, 16'd60000, 16'd20, 16'd40000, 16'd0, 16'hFFFF};
      load_curve(xs, ys, 16'd5);
      send_sample(CH_MIN, 16'd350, 16'd0);
      send_sample(4'd2, 16'd550, 16'd0);
      send_sample(4'd3, 16'd601, 16'd0);
      send_sample(4'd4, 16'd500, 16'hFFFA);
      drain_pipeline();
   endtask

   // Random traffic under each idling mode and a range of curves.
   task automatic test_random_traffic();
      bld_pts_type xs, ys;
      int          step_x;
      for (int mode = 0; mode < 3; mode++) begin
         req_idle_pct = (mode == 0) ? 15 : (mode == 1) ? 85 : 0;
         rsp_stall_pct = (mode == 0) ? 85 : (mode == 1) ? 15 : 0;
         for (int shape = 0; shape < 4; shape++) begin
            if (shape < 2) begin
               // Ascending breakpoints, repeated points allowed.
               step_x = $urandom_range(0, 5000);
               for (int k = 0; k < PTS; k++) begin
                  xs[k] = step_x[15:0];
                  ys[k] = 16'($urandom());
                  step_x = step_x + $urandom_range(0, 12000);
               end
               load_curve(xs, ys, 16'($urandom_range(0, 300)));
            end else if (shape == 2) begin
               for (int k = 0; k < PTS; k++) begin
                  xs[k] = 16'($urandom());
                  ys[k] = 16'($urandom());
               end
               load_curve(xs, ys, 16'($urandom_range(0, 2000)));
            end else begin
               // Full-scale swings across the whole input range.
               xs = {16'hFFFF, 16'hFFFE, 16'h8000, 16'h7FFF, 16'd1, 16'd0};
               ys = {16'd0, 16'hFFFF, 16'd0, 16'hFFFF, 16'd0, 16'hFFFF};
               load_curve(xs, ys, 16'd0);
            end
            stream_random_samples(ITEMS_PER_CURVE);
            drain_pipeline();
         end
      end
   endtask

   // Compare each reading with the oldest prediction.
   always @(posedge clock) begin
      reading_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_readings.size() == 0) begin
            $error("unexpected reading: value %0d held %0d", rsp_tdata, rsp_tuser);
            mismatch_count++;
         end else begin
            want = pending_readings.pop_front();
            if (rsp_tdata !== want.value) begin
               $error("value: expected %0d, actual %0d", want.value, rsp_tdata);
               mismatch_count++;
            end
            if (rsp_tuser !== want.held) begin
               $error("held: expected %0d, actual %0d", want.held, rsp_tuser);
               mismatch_count++;
            end
         end
      end
   end

   // Watchdog on cycles without any transaction.
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)
          || (csr_valid && csr_ready)) begin
         hang_cycles <= 0;
      end else if (hang_cycles + 1 >= HANG_LIMIT) begin
         $display("breakpoint_linearizer_deadband regression: fail");
         $finish;
      end else begin
         hang_cycles <= hang_cycles + 1;
      end
   end

   // Test sequence.
   initial begin
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_reset_curve();
      test_register_writes();
      test_random_traffic();
      if (mismatch_count == 0 && pending_readings.size() == 0) begin
         $display("breakpoint_linearizer_deadband regression: pass");
      end else begin
         $display("breakpoint_linearizer_deadband regression: fail");
      end
      $finish;
   end

endmodule
